// ----- hw/rtl/linear_adsr_envelope_unit_assert.svh -----
// Assertion macros for the ADSR envelope unit checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef LINEAR_ADSR_ENVELOPE_UNIT_ASSERT_SVH
`define LINEAR_ADSR_ENVELOPE_UNIT_ASSERT_SVH

// same-cycle implication
`define LAE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lae_pkg.sv -----
// Shared types and constants for the linear ADSR envelope unit.
// No dependencies; imported by the divider, the top level and the checker.
`default_nettype none

package lae_pkg;

  localparam int TIME_SCALE_DEF    = 15000;
  localparam int AMP_FRAC_BITS_DEF = 24;

  localparam int KNOB_W     = 16;
  localparam int SUS_W      = 25;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic [SUS_W-1:0] SUS_RESET = 25'd8388608;

  // snap thresholds: EPS = ONE/10000, HI = ONE*99/100
  localparam longint EPS_DIV = 10000;
  localparam longint HI_NUM  = 99;
  localparam longint HI_DEN  = 100;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_UPDATE,
    ST_SCALE,
    ST_DONE
  } lae_state_t;

  typedef enum logic [1:0] {
    MODE_RELEASE,
    MODE_ATTACK,
    MODE_DECAY,
    MODE_HOLD
  } lae_mode_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lae_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Uses lae_pkg; instantiated by linear_adsr_envelope_unit.
`default_nettype none

module lae_div #(
  parameter int QW = lae_pkg::AMP_FRAC_BITS_DEF + 1,
  parameter int DW = lae_pkg::KNOB_W + 2,
  parameter int LW = lae_pkg::KNOB_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [QW+LW-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic             done,
  output logic [QW-1:0]    quotient
);
  import lae_pkg::*;

  localparam int CNTW = $clog2(QW + 1);

  logic [DW-1:0]   rem_r;
  logic [QW-1:0]   q_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [DW:0] rem_sh;
  logic [DW:0] diff;
  logic        ge;

  // upper dividend bits are known to sit below the divisor, so only QW steps
  assign rem_sh = {rem_r, q_r[QW-1]};
  assign diff   = rem_sh - {1'b0, divisor};
  assign ge     = ~diff[DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DW'(dividend[QW+LW-1:QW]);
      q_r   <= dividend[QW-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

// ----- hw/rtl/linear_adsr_envelope_unit.sv -----
// Linear ADSR envelope unit: one input word per audio tick (gate, oscillator
// sample) gives one result word (envelope amplitude, scaled sample). A new
// input word is taken only once the last one is through. Each word passes, in
// order, the idle state in which it is taken, the phase-time multiply, the
// divider load, the shared restoring divider (AMP_FRAC_BITS+1 step-size bits,
// one at a time), the divider done flag, the state update, the sample multiply
// and the output load. in_stall stays high while an item is in flight. The
// result sits in an output register, so a waiting result does not block the
// next item until that item's own result is ready; a stalled output holds the
// unit in its done state. Configuration writes are taken every cycle (cfg_ready
// is tied high) and must happen while the unit is idle.
// Uses lae_pkg and lae_div.
`default_nettype none

module linear_adsr_envelope_unit #(
  parameter int TIME_SCALE    = lae_pkg::TIME_SCALE_DEF,
  parameter int AMP_FRAC_BITS = lae_pkg::AMP_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lae_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lae_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_gate,
  input  logic signed [lae_pkg::SAMPLE_W-1:0] in_osc_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [AMP_FRAC_BITS:0]              out_envelope,
  output logic signed [lae_pkg::SAMPLE_W-1:0] out_scaled_sample
);
  import lae_pkg::*;

  localparam int AW  = AMP_FRAC_BITS + 1;
  localparam int TSW = $clog2(TIME_SCALE + 1);
  localparam int DW  = TSW + KNOB_W + 1;
  localparam int NW  = AW + KNOB_W;
  localparam int CW  = (AW > SUS_W) ? AW : SUS_W;
  localparam int PW  = SAMPLE_W + AW + 1;

  localparam logic [AW-1:0] AMP_ONE = AW'(1) << AMP_FRAC_BITS;
  localparam logic [AW-1:0] AMP_EPS = AW'((longint'(1) << AMP_FRAC_BITS) / EPS_DIV);
  localparam logic [AW-1:0] AMP_HI  =
    AW'(((longint'(1) << AMP_FRAC_BITS) * HI_NUM) / HI_DEN);
  localparam logic [CW-1:0] ONE_EXT = CW'(1) << AMP_FRAC_BITS;
  localparam logic [TSW-1:0] TS_K   = TSW'(TIME_SCALE);

  lae_state_t state_r, state_nxt;
  lae_mode_t  mode;

  logic [KNOB_W-1:0] attack_knob_r, decay_knob_r, release_knob_r;
  logic [SUS_W-1:0]  sustain_r;

  logic [AW-1:0] amp_r;
  logic          armed_r;
  logic          decay_r;

  logic                       gate_r;
  logic signed [SAMPLE_W-1:0] osc_r;
  logic [DW-1:0]              t_r;
  logic [NW-1:0]              dvd_r;
  logic signed [PW-1:0]       prod_r;

  logic                       out_valid_r;
  logic [AW-1:0]              out_env_r;
  logic signed [SAMPLE_W-1:0] out_smp_r;

  logic          acc_en, mul_en, div_start, upd_en, scale_en, out_load;
  logic          div_done;
  logic [AW-1:0] step;
  logic [AW-1:0] sus_c;
  logic [CW-1:0] sus_ext;
  logic [AW-1:0] x_sel;
  logic [KNOB_W-1:0] knob_sel;
  logic [AW-1:0] diff;
  logic [AW:0]   sum;
  logic [AW-1:0] amp_upd;
  logic          armed_upd, decay_upd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_knob_r  <= '0;
      decay_knob_r   <= '0;
      release_knob_r <= '0;
      sustain_r      <= SUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ATTACK:  attack_knob_r  <= cfg_data[KNOB_W-1:0];
        CFG_DECAY:   decay_knob_r   <= cfg_data[KNOB_W-1:0];
        CFG_RELEASE: release_knob_r <= cfg_data[KNOB_W-1:0];
        CFG_SUSTAIN: sustain_r      <= cfg_data[SUS_W-1:0];
      endcase
    end
  end

  // sustain above full scale is taken as full scale
  assign sus_ext = CW'(sustain_r);
  assign sus_c   = (sus_ext > ONE_EXT) ? AMP_ONE : AW'(sus_ext);

  always_comb begin
    priority if (!gate_r) mode = MODE_RELEASE;
    else if (armed_r)     mode = MODE_ATTACK;
    else if (decay_r)     mode = MODE_DECAY;
    else                  mode = MODE_HOLD;
  end

  always_comb begin
    unique case (mode)
      MODE_RELEASE: begin
        x_sel    = sus_c;
        knob_sel = release_knob_r;
      end
      MODE_ATTACK: begin
        x_sel    = AMP_ONE;
        knob_sel = attack_knob_r;
      end
      MODE_DECAY: begin
        x_sel    = AMP_ONE - sus_c;
        knob_sel = decay_knob_r;
      end
      MODE_HOLD: begin
        x_sel    = '0;
        knob_sel = '0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_DIV;
      ST_DIV:    if (div_done) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    acc_en    = (state_r == ST_IDLE) && in_valid;
    mul_en    = (state_r == ST_MUL);
    div_start = (state_r == ST_LOAD);
    upd_en    = (state_r == ST_UPDATE);
    scale_en  = (state_r == ST_SCALE);
    out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (acc_en) begin
      gate_r <= in_gate;
      osc_r  <= in_osc_sample;
    end
    // phase time in Q.16 ticks: TIME_SCALE*knob + 1.0
    if (mul_en) begin
      t_r   <= DW'(TS_K) * DW'(knob_sel) + (DW'(1) << KNOB_W);
      dvd_r <= {x_sel, KNOB_W'(0)};
    end
    if (scale_en) prod_r <= $signed(osc_r) * $signed({1'b0, amp_r});
  end

  lae_div #(
    .QW(AW),
    .DW(DW),
    .LW(KNOB_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(dvd_r),
    .divisor (t_r),
    .done    (div_done),
    .quotient(step)
  );

  assign diff = amp_r - step;
  assign sum  = {1'b0, amp_r} + {1'b0, step};

  always_comb begin
    amp_upd   = amp_r;
    armed_upd = armed_r;
    decay_upd = decay_r;
    unique case (mode)
      MODE_RELEASE: begin
        armed_upd = 1'b1;
        if (step >= amp_r || diff < AMP_EPS) amp_upd = '0;
        else                                 amp_upd = diff;
      end
      MODE_ATTACK: begin
        if (sum > {1'b0, AMP_HI}) begin
          amp_upd   = AMP_ONE;
          armed_upd = 1'b0;
          decay_upd = 1'b1;
        end else begin
          amp_upd = sum[AW-1:0];
        end
      end
      MODE_DECAY: begin
        if (step > amp_r || diff < sus_c) begin
          amp_upd   = sus_c;
          decay_upd = 1'b0;
        end else begin
          amp_upd = diff;
        end
      end
      MODE_HOLD: amp_upd = sus_c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r   <= '0;
      armed_r <= 1'b1;
      decay_r <= 1'b0;
    end else if (upd_en) begin
      amp_r   <= amp_upd;
      armed_r <= armed_upd;
      decay_r <= decay_upd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_env_r <= amp_r;
      // arithmetic shift keeps the floor for negative products
      out_smp_r <= prod_r[AMP_FRAC_BITS +: SAMPLE_W];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_envelope      = out_env_r;
  assign out_scaled_sample = out_smp_r;

endmodule

`default_nettype wire

// ----- hw/rtl/lae_checker.sv -----
// Port-level checks for linear_adsr_envelope_unit, bound to the top level.
// Uses lae_pkg and the macros in linear_adsr_envelope_unit_assert.svh.
`default_nettype none
`include "linear_adsr_envelope_unit_assert.svh"

module lae_checker #(
  parameter int AMP_FRAC_BITS = lae_pkg::AMP_FRAC_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [AMP_FRAC_BITS:0]              out_envelope,
  input logic signed [lae_pkg::SAMPLE_W-1:0] out_scaled_sample
);
  import lae_pkg::*;

  localparam logic [AMP_FRAC_BITS:0] AMP_ONE = (AMP_FRAC_BITS + 1)'(1) << AMP_FRAC_BITS;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // the unit is busy right after taking a word
  `LAE_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "accepted word did not stall input")

  // no result can appear in the cycle after a word is taken
  `LAE_ASSERT_NEXT(a_no_early_result, in_acc, !$rose(out_valid), "result too soon after accept")

  // held result stays put while stalled
  `LAE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_envelope) && $stable(out_scaled_sample), "stalled result changed")

  // amplitude never exceeds full scale
  `LAE_ASSERT_NOW(a_env_range, out_valid, out_envelope <= AMP_ONE, "envelope above full scale")

endmodule

bind linear_adsr_envelope_unit lae_checker #(
  .AMP_FRAC_BITS(AMP_FRAC_BITS)
) u_lae_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_envelope     (out_envelope),
  .out_scaled_sample(out_scaled_sample)
);

`default_nettype wire
